/* hw/rtl/mdc_pkg.sv */
package mdc_pkg;

  localparam int MaxParamsDefault = 255;
  localparam int ResFifoDepth     = 4;

  localparam logic [7:0] CH_OPEN  = 8'h28;  // '('
  localparam logic [7:0] CH_CLOSE = 8'h29;  // ')'
  localparam logic [7:0] CH_SEMI  = 8'h3B;  // ';'
  localparam logic [7:0] CH_ARRAY = 8'h5B;  // '['
  localparam logic [7:0] CH_VOID  = 8'h56;  // 'V'
  localparam logic [7:0] CH_CLASS = 8'h4C;  // 'L'
  localparam logic [7:0] CH_INT   = 8'h49;  // 'I'
  localparam logic [7:0] CH_LONG  = 8'h4A;  // 'J'
  localparam logic [7:0] CH_FLT   = 8'h46;  // 'F'
  localparam logic [7:0] CH_DBL   = 8'h44;  // 'D'
  localparam logic [7:0] CH_BOOL  = 8'h5A;  // 'Z'
  localparam logic [7:0] CH_BYTE  = 8'h42;  // 'B'
  localparam logic [7:0] CH_CHAR  = 8'h43;  // 'C'
  localparam logic [7:0] CH_SHORT = 8'h53;  // 'S'

  localparam logic [2:0] TC_VOID = 3'd0;
  localparam logic [2:0] TC_INT  = 3'd1;
  localparam logic [2:0] TC_LONG = 3'd2;
  localparam logic [2:0] TC_FLT  = 3'd3;
  localparam logic [2:0] TC_DBL  = 3'd4;
  localparam logic [2:0] TC_REF  = 3'd5;

  localparam logic RK_PARAM   = 1'b0;
  localparam logic RK_SUMMARY = 1'b1;

  typedef struct packed {
    logic       result_kind;
    logic [2:0] type_code;
    logic       params_ok;
    logic       descriptor_ok;
    logic [7:0] param_count;
    logic       count_saturated;
  } res_t;

  // Zero, one or two results produced by one descriptor byte, in order a then b.
  typedef struct packed {
    logic [1:0] n;
    res_t       a;
    res_t       b;
  } push_t;

  // Type code of a primitive that may stand alone, else TC_VOID.
  function automatic logic [2:0] plain_code(input logic [7:0] c);
    logic [2:0] code;
    case (c)
      CH_INT:  code = TC_INT;
      CH_LONG: code = TC_LONG;
      CH_FLT:  code = TC_FLT;
      CH_DBL:  code = TC_DBL;
      default: code = TC_VOID;
    endcase
    return code;
  endfunction

  function automatic logic elem_primitive(input logic [7:0] c);
    return (plain_code(c) != TC_VOID) || (c inside {CH_BOOL, CH_BYTE, CH_CHAR, CH_SHORT});
  endfunction

endpackage

/* hw/rtl/mdc_parser.sv */
module mdc_parser #(
  parameter int MAX_PARAMS = mdc_pkg::MaxParamsDefault
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           step_en,
  input  logic [7:0]     ch,
  input  logic           last,
  output mdc_pkg::push_t push
);
  import mdc_pkg::*;

  localparam int CountLimit = (MAX_PARAMS > 255) ? 255 : MAX_PARAMS;

  typedef enum logic [3:0] {
    PH_OPEN   = 4'd0,
    PH_PSTART = 4'd1,
    PH_PARR   = 4'd2,
    PH_PNAME  = 4'd3,
    PH_RSTART = 4'd4,
    PH_RARR   = 4'd5,
    PH_RNAME  = 4'd6,
    PH_RDONE  = 4'd7,
    PH_PBAD   = 4'd8,
    PH_RBAD   = 4'd9
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic       name_empty_r, name_empty_nxt;
  logic [7:0] count_r, count_nxt;
  logic       ovf_r, ovf_nxt;
  logic       closed_r, closed_nxt;
  logic [2:0] ret_kind_r, ret_kind_nxt;

  logic       done_param;
  logic [2:0] done_code;
  logic       name_done;
  logic       name_bad;
  logic       pok;
  logic       dok;
  res_t       param_res;
  res_t       sum_res;

  // A class name ends on ';' if it is non-empty; '(', ')' and '[' are illegal inside it.
  always_comb begin
    name_done = (ch == CH_SEMI) && !name_empty_r;
    name_bad  = ((ch == CH_SEMI) && name_empty_r) || (ch inside {CH_OPEN, CH_CLOSE, CH_ARRAY});
  end

  always_comb begin
    phase_nxt      = phase_r;
    name_empty_nxt = name_empty_r;
    count_nxt      = count_r;
    ovf_nxt        = ovf_r;
    closed_nxt     = closed_r;
    ret_kind_nxt   = ret_kind_r;
    done_param     = 1'b0;
    done_code      = TC_VOID;

    case (phase_r)
      PH_OPEN: begin
        phase_nxt = (ch == CH_OPEN) ? PH_PSTART : PH_PBAD;
      end
      PH_PSTART: begin
        if (ch == CH_CLOSE) begin
          closed_nxt = 1'b1;
          phase_nxt  = PH_RSTART;
        end else if (plain_code(ch) != TC_VOID) begin
          done_param = 1'b1;
          done_code  = plain_code(ch);
        end else if (ch == CH_CLASS) begin
          name_empty_nxt = 1'b1;
          phase_nxt      = PH_PNAME;
        end else if (ch == CH_ARRAY) begin
          phase_nxt = PH_PARR;
        end else begin
          phase_nxt = PH_PBAD;
        end
      end
      PH_PARR: begin
        if (ch == CH_ARRAY) begin
          phase_nxt = PH_PARR;
        end else if (elem_primitive(ch)) begin
          done_param = 1'b1;
          done_code  = TC_REF;
          phase_nxt  = PH_PSTART;
        end else if (ch == CH_CLASS) begin
          name_empty_nxt = 1'b1;
          phase_nxt      = PH_PNAME;
        end else begin
          phase_nxt = PH_PBAD;
        end
      end
      PH_PNAME: begin
        if (name_done) begin
          done_param = 1'b1;
          done_code  = TC_REF;
          phase_nxt  = PH_PSTART;
        end else if (name_bad) begin
          phase_nxt = PH_PBAD;
        end else begin
          name_empty_nxt = 1'b0;
        end
      end
      PH_RSTART: begin
        if (ch == CH_VOID) begin
          ret_kind_nxt = TC_VOID;
          phase_nxt    = PH_RDONE;
        end else if (plain_code(ch) != TC_VOID) begin
          ret_kind_nxt = plain_code(ch);
          phase_nxt    = PH_RDONE;
        end else if (ch == CH_CLASS) begin
          name_empty_nxt = 1'b1;
          phase_nxt      = PH_RNAME;
        end else if (ch == CH_ARRAY) begin
          phase_nxt = PH_RARR;
        end else begin
          phase_nxt = PH_RBAD;
        end
      end
      PH_RARR: begin
        if (ch == CH_ARRAY) begin
          phase_nxt = PH_RARR;
        end else if (elem_primitive(ch)) begin
          ret_kind_nxt = TC_REF;
          phase_nxt    = PH_RDONE;
        end else if (ch == CH_CLASS) begin
          name_empty_nxt = 1'b1;
          phase_nxt      = PH_RNAME;
        end else begin
          phase_nxt = PH_RBAD;
        end
      end
      PH_RNAME: begin
        if (name_done) begin
          ret_kind_nxt = TC_REF;
          phase_nxt    = PH_RDONE;
        end else if (name_bad) begin
          phase_nxt = PH_RBAD;
        end else begin
          name_empty_nxt = 1'b0;
        end
      end
      PH_RDONE: begin
        phase_nxt = PH_RBAD;
      end
      PH_RBAD: begin
        phase_nxt = PH_RBAD;
      end
      PH_PBAD: begin
        phase_nxt = PH_PBAD;
      end
      default: begin
        phase_nxt = PH_PBAD;
      end
    endcase

    if (done_param) begin
      if (count_r >= 8'(CountLimit)) begin
        ovf_nxt = 1'b1;
      end else begin
        count_nxt = count_r + 8'd1;
      end
    end
  end

  // The summary sees the state as updated by the final byte itself.
  always_comb begin
    pok = closed_nxt;
    dok = pok && (phase_nxt == PH_RDONE);

    param_res                 = '0;
    param_res.result_kind     = RK_PARAM;
    param_res.type_code       = done_code;

    sum_res                   = '0;
    sum_res.result_kind       = RK_SUMMARY;
    sum_res.type_code         = dok ? ret_kind_nxt : TC_VOID;
    sum_res.params_ok         = pok;
    sum_res.descriptor_ok     = dok;
    sum_res.param_count       = pok ? count_nxt : 8'd0;
    sum_res.count_saturated   = pok && ovf_nxt;

    push.n = 2'b00;
    push.a = done_param ? param_res : sum_res;
    push.b = sum_res;
    if (step_en) begin
      push.n = 2'({1'b0, done_param} + {1'b0, last});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_OPEN;
      name_empty_r <= 1'b0;
      count_r      <= 8'd0;
      ovf_r        <= 1'b0;
      closed_r     <= 1'b0;
      ret_kind_r   <= TC_VOID;
    end else if (step_en) begin
      if (last) begin
        phase_r      <= PH_OPEN;
        name_empty_r <= 1'b0;
        count_r      <= 8'd0;
        ovf_r        <= 1'b0;
        closed_r     <= 1'b0;
        ret_kind_r   <= TC_VOID;
      end else begin
        phase_r      <= phase_nxt;
        name_empty_r <= name_empty_nxt;
        count_r      <= count_nxt;
        ovf_r        <= ovf_nxt;
        closed_r     <= closed_nxt;
        ret_kind_r   <= ret_kind_nxt;
      end
    end
  end

endmodule

/* hw/rtl/mdc_res_fifo.sv */
module mdc_res_fifo #(
  parameter int DEPTH = mdc_pkg::ResFifoDepth
) (
  input  logic           clk,
  input  logic           rst_n,
  input  mdc_pkg::push_t push,
  output logic           room,
  output logic           out_valid,
  input  logic           out_stall,
  output mdc_pkg::res_t  out_res
);
  import mdc_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = AW + 1;

  res_t          mem_r [DEPTH];
  logic [AW-1:0] wp_r, wp_nxt;
  logic [AW-1:0] rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0] wp_plus1;
  logic          pop;

  assign out_valid = (cnt_r != '0);
  assign out_res   = mem_r[rp_r];
  assign pop       = out_valid && !out_stall;
  // Room for the worst case of two results from one byte.
  assign room      = (cnt_r <= CW'(DEPTH - 2));
  assign wp_plus1  = AW'((DEPTH == (1 << AW)) ? (wp_r + 1'b1)
                                               : ((wp_r == AW'(DEPTH - 1)) ? 0 : wp_r + 1'b1));

  always_comb begin
    wp_nxt = wp_r;
    rp_nxt = rp_r;
    if (push.n == 2'd1) begin
      wp_nxt = wp_plus1;
    end else if (push.n == 2'd2) begin
      wp_nxt = (wp_plus1 == AW'(DEPTH - 1)) ? '0 : AW'(wp_plus1 + 1'b1);
    end
    if (pop) begin
      rp_nxt = (rp_r == AW'(DEPTH - 1)) ? '0 : AW'(rp_r + 1'b1);
    end
    cnt_nxt = cnt_r + CW'(push.n) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem_r[wp_r] <= push.a;
    end
    if (push.n == 2'd2) begin
      mem_r[wp_plus1] <= push.b;
    end
  end

endmodule

/* hw/rtl/method_descriptor_checker_unit.sv */
// A byte is taken into the input register and stepped by the parser once the queue has
// room. Throughput: one descriptor byte per cycle while in_stall is low; the input
// register feeds the parser, and a four-entry result queue absorbs the extra summary
// a final byte produces, which leaves the queue after the parameter result of that byte.
// in_stall rises only while the queue cannot take two more results.
// Reset (rst_n low, synchronous) returns the parser to expect '(' and empties the queue.
module method_descriptor_checker_unit #(
  parameter int MAX_PARAMS = mdc_pkg::MaxParamsDefault
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_ch,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_result_kind,
  output logic [2:0] out_type_code,
  output logic       out_params_ok,
  output logic       out_descriptor_ok,
  output logic [7:0] out_param_count,
  output logic       out_count_saturated
);
  import mdc_pkg::*;

  logic       in_vld_r;
  logic [7:0] in_ch_r;
  logic       in_last_r;
  logic       room;
  logic       step_en;
  logic       in_fire;
  push_t      push;
  res_t       res;

  assign step_en  = in_vld_r && room;
  assign in_stall = in_vld_r && !room;
  assign in_fire  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_fire) begin
      in_vld_r <= 1'b1;
    end else if (step_en) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_ch_r   <= in_ch;
      in_last_r <= in_last;
    end
  end

  mdc_parser #(
    .MAX_PARAMS(MAX_PARAMS)
  ) u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .ch      (in_ch_r),
    .last    (in_last_r),
    .push    (push)
  );

  mdc_res_fifo #(
    .DEPTH(ResFifoDepth)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (res)
  );

  assign out_result_kind     = res.result_kind;
  assign out_type_code       = res.type_code;
  assign out_params_ok       = res.params_ok;
  assign out_descriptor_ok   = res.descriptor_ok;
  assign out_param_count     = res.param_count;
  assign out_count_saturated = res.count_saturated;

endmodule

/* test/mdc_result_checker.sv */
`timescale 1ns / 1ps

module mdc_result_checker #(
  parameter int MaxParams = mdc_pkg::MaxParamsDefault
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_ch,
  input  logic       in_last,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic       out_result_kind,
  input  logic [2:0] out_type_code,
  input  logic       out_params_ok,
  input  logic       out_descriptor_ok,
  input  logic [7:0] out_param_count,
  input  logic       out_count_saturated,
  output int         error_count,
  output int         expected_left,
  output int         results_checked
);
  import mdc_pkg::*;

  // The count field is eight bits wide, so it can never hold more than 255.
  localparam int CountCap = (MaxParams > 255) ? 255 : MaxParams;

  typedef enum logic [3:0] {
    P_OPEN, P_START, P_ARRAY, P_NAME,
    R_START, R_ARRAY, R_NAME, R_DONE,
    P_BAD, R_BAD
  } parse_state_t;

  parse_state_t state;
  logic         name_empty;
  logic [7:0]   count;
  logic         count_held;
  logic         closed;
  logic [2:0]   ret_code;
  res_t         expected_results[$];

  function automatic logic [2:0] scalar_code(input logic [7:0] c);
    logic [2:0] code;
    case (c)
      CH_INT:  code = TC_INT;
      CH_LONG: code = TC_LONG;
      CH_FLT:  code = TC_FLT;
      CH_DBL:  code = TC_DBL;
      default: code = TC_VOID;
    endcase
    return code;
  endfunction

  function automatic logic is_array_elem(input logic [7:0] c);
    return scalar_code(c) != TC_VOID || c == CH_BOOL || c == CH_BYTE ||
           c == CH_CHAR || c == CH_SHORT;
  endfunction

  function automatic logic breaks_name(input logic [7:0] c);
    return c == CH_OPEN || c == CH_CLOSE || c == CH_ARRAY;
  endfunction

  task automatic clear_parser();
    state      = P_OPEN;
    name_empty = 1'b0;
    count      = 8'd0;
    count_held = 1'b0;
    closed     = 1'b0;
    ret_code   = TC_VOID;
  endtask

  task automatic parse_byte(input logic [7:0] c, input logic is_last);
    logic       param_done;
    logic [2:0] done_code;
    res_t       r;
    param_done = 1'b0;
    done_code  = TC_VOID;
    case (state)
      P_OPEN: state = (c == CH_OPEN) ? P_START : P_BAD;
      P_START: begin
        if (c == CH_CLOSE) begin
          closed = 1'b1;
          state  = R_START;
        end else if (scalar_code(c) != TC_VOID) begin
          param_done = 1'b1;
          done_code  = scalar_code(c);
        end else if (c == CH_CLASS) begin
          name_empty = 1'b1;
          state      = P_NAME;
        end else if (c == CH_ARRAY) begin
          state = P_ARRAY;
        end else begin
          state = P_BAD;
        end
      end
      P_ARRAY: begin
        if (is_array_elem(c)) begin
          param_done = 1'b1;
          done_code  = TC_REF;
          state      = P_START;
        end else if (c == CH_CLASS) begin
          name_empty = 1'b1;
          state      = P_NAME;
        end else if (c != CH_ARRAY) begin
          state = P_BAD;
        end
      end
      P_NAME: begin
        if (c == CH_SEMI) begin
          if (name_empty) begin
            state = P_BAD;
          end else begin
            param_done = 1'b1;
            done_code  = TC_REF;
            state      = P_START;
          end
        end else if (breaks_name(c)) begin
          state = P_BAD;
        end else begin
          name_empty = 1'b0;
        end
      end
      R_START: begin
        if (c == CH_VOID) begin
          ret_code = TC_VOID;
          state    = R_DONE;
        end else if (scalar_code(c) != TC_VOID) begin
          ret_code = scalar_code(c);
          state    = R_DONE;
        end else if (c == CH_CLASS) begin
          name_empty = 1'b1;
          state      = R_NAME;
        end else if (c == CH_ARRAY) begin
          state = R_ARRAY;
        end else begin
          state = R_BAD;
        end
      end
      R_ARRAY: begin
        if (is_array_elem(c)) begin
          ret_code = TC_REF;
          state    = R_DONE;
        end else if (c == CH_CLASS) begin
          name_empty = 1'b1;
          state      = R_NAME;
        end else if (c != CH_ARRAY) begin
          state = R_BAD;
        end
      end
      R_NAME: begin
        if (c == CH_SEMI) begin
          if (name_empty) begin
            state = R_BAD;
          end else begin
            ret_code = TC_REF;
            state    = R_DONE;
          end
        end else if (breaks_name(c)) begin
          state = R_BAD;
        end else begin
          name_empty = 1'b0;
        end
      end
      R_DONE: state = R_BAD;
      default: ;
    endcase

    if (param_done) begin
      if (count >= CountCap) begin
        count_held = 1'b1;
      end else begin
        count = count + 8'd1;
      end
      r             = '0;
      r.result_kind = RK_PARAM;
      r.type_code   = done_code;
      expected_results.insert(expected_results.size(), r);
    end

    if (is_last) begin
      r                 = '0;
      r.result_kind     = RK_SUMMARY;
      r.params_ok       = closed;
      r.descriptor_ok   = closed && state == R_DONE;
      r.type_code       = r.descriptor_ok ? ret_code : TC_VOID;
      r.param_count     = closed ? count : 8'd0;
      r.count_saturated = closed & count_held;
      expected_results.insert(expected_results.size(), r);
      clear_parser();
    end
  endtask

  task automatic check_field(input string what, input int want, input int got);
    if (want != got) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin
    res_t head;
    if (!rst_n) begin
      clear_parser();
      expected_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          error_count++;
          $display("%0t: result transfer with none expected, kind %0d type %0d",
                   $time, out_result_kind, out_type_code);
        end else begin
          head = expected_results.pop_front();
          results_checked++;
          check_field("result_kind", head.result_kind, out_result_kind);
          check_field("type_code", head.type_code, out_type_code);
          check_field("params_ok", head.params_ok, out_params_ok);
          check_field("descriptor_ok", head.descriptor_ok, out_descriptor_ok);
          check_field("param_count", head.param_count, out_param_count);
          check_field("count_saturated", head.count_saturated, out_count_saturated);
        end
      end
      if (in_valid && !in_stall) begin
        parse_byte(in_ch, in_last);
      end
    end
    expected_left = expected_results.size();
  end

endmodule

/* test/tb_method_descriptor_checker_unit.sv */
`timescale 1ns / 1ps

module tb_method_descriptor_checker_unit;
  import mdc_pkg::*;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_ch = 8'h00;
  logic       in_last = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_result_kind;
  logic [2:0] out_type_code;
  logic       out_params_ok;
  logic       out_descriptor_ok;
  logic [7:0] out_param_count;
  logic       out_count_saturated;

  int error_count;
  int expected_left;
  int results_checked;

  bit         tx_gaps = 1'b0;
  bit         rx_gaps = 1'b0;
  bit         hold_output = 1'b0;
  int         bytes_sent = 0;
  int         descriptors_sent = 0;
  logic [7:0] desc_bytes[$];

  always #10 clk = ~clk;

  method_descriptor_checker_unit dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_ch              (in_ch),
    .in_last            (in_last),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_result_kind    (out_result_kind),
    .out_type_code      (out_type_code),
    .out_params_ok      (out_params_ok),
    .out_descriptor_ok  (out_descriptor_ok),
    .out_param_count    (out_param_count),
    .out_count_saturated(out_count_saturated)
  );

  mdc_result_checker result_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_ch              (in_ch),
    .in_last            (in_last),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_result_kind    (out_result_kind),
    .out_type_code      (out_type_code),
    .out_params_ok      (out_params_ok),
    .out_descriptor_ok  (out_descriptor_ok),
    .out_param_count    (out_param_count),
    .out_count_saturated(out_count_saturated),
    .error_count        (error_count),
    .expected_left      (expected_left),
    .results_checked    (results_checked)
  );

  initial begin
    #4_000_000;
    $display("Timed out with %0d results still outstanding.", expected_left);
    $display("DONE: errors detected");
    $finish;
  end

  // Receiver side: random stall bursts, plus one long hold-off on request.
  always begin
    @(negedge clk);
    if (hold_output) begin
      out_stall <= 1'b1;
      repeat (64) @(negedge clk);
      out_stall <= 1'b0;
      hold_output = 1'b0;
    end else if (rx_gaps && $urandom_range(0, 3) == 0) begin
      out_stall <= 1'b1;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      out_stall <= 1'b0;
    end
  end

  // Called and returning at a falling edge; the byte is held until its transfer.
  task automatic send_byte(input logic [7:0] c, input logic is_last);
    if (tx_gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_ch    <= c;
    in_last  <= is_last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic add_byte(input logic [7:0] c);
    desc_bytes.insert(desc_bytes.size(), c);
  endtask

  task automatic send_descriptor();
    foreach (desc_bytes[i]) begin
      send_byte(desc_bytes[i], i == desc_bytes.size() - 1);
    end
    descriptors_sent++;
  endtask

  task automatic send_text(input string s);
    desc_bytes.delete();
    for (int i = 0; i < s.len(); i++) begin
      add_byte(s[i]);
    end
    send_descriptor();
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (expected_left != 0);
  endtask

  function automatic logic [7:0] scalar_char();
    logic [7:0] c;
    case ($urandom_range(0, 3))
      0:       c = CH_INT;
      1:       c = CH_LONG;
      2:       c = CH_FLT;
      default: c = CH_DBL;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] array_elem_char();
    logic [7:0] c;
    case ($urandom_range(0, 7))
      0:       c = CH_BOOL;
      1:       c = CH_BYTE;
      2:       c = CH_CHAR;
      3:       c = CH_SHORT;
      default: c = scalar_char();
    endcase
    return c;
  endfunction

  // Characters that are only legal in some positions, or not at all.
  function automatic logic [7:0] stray_char();
    logic [7:0] c;
    case ($urandom_range(0, 9))
      0:       c = CH_BOOL;
      1:       c = CH_BYTE;
      2:       c = CH_CHAR;
      3:       c = CH_SHORT;
      4:       c = CH_VOID;
      5:       c = CH_OPEN;
      6:       c = CH_ARRAY;
      7:       c = CH_SEMI;
      8:       c = CH_CLOSE;
      default: c = CH_CLASS;
    endcase
    return c;
  endfunction

  task automatic add_class_name();
    logic [7:0] c;
    add_byte(CH_CLASS);
    repeat ($urandom_range(1, 4)) begin
      do c = 8'($urandom_range(0, 255));
      while (c == CH_OPEN || c == CH_CLOSE || c == CH_ARRAY || c == CH_SEMI);
      add_byte(c);
    end
    add_byte(CH_SEMI);
  endtask

  task automatic add_type(input bit for_return);
    case ($urandom_range(0, for_return ? 4 : 3))
      0, 3: add_byte(scalar_char());
      1: add_class_name();
      2: begin
        repeat ($urandom_range(1, 3)) add_byte(CH_ARRAY);
        if ($urandom_range(0, 2) == 0) begin
          add_class_name();
        end else begin
          add_byte(array_elem_char());
        end
      end
      default: add_byte(CH_VOID);
    endcase
  endtask

  task automatic build_wellformed();
    desc_bytes.delete();
    add_byte(CH_OPEN);
    repeat ($urandom_range(0, 5)) add_type(1'b0);
    add_byte(CH_CLOSE);
    add_type(1'b1);
  endtask

  task automatic damage_descriptor();
    int pos;
    int keep;
    pos = $urandom_range(0, desc_bytes.size() - 1);
    case ($urandom_range(0, 4))
      0: desc_bytes[pos] = 8'($urandom);
      1: begin
        keep = $urandom_range(1, desc_bytes.size() - 1);
        while (desc_bytes.size() > keep) void'(desc_bytes.pop_back());
      end
      2: repeat ($urandom_range(1, 2)) add_byte(stray_char());
      3: desc_bytes.insert(pos, stray_char());
      default: begin
        desc_bytes.delete();
        repeat ($urandom_range(1, 6)) add_byte(8'($urandom));
      end
    endcase
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
    send_text("()V");
    send_text("(J[Z)D");
    send_text("(L;");
    send_text("()S");
    send_text("()[V");
    send_text("()VI");
    // The final byte completes a parameter, so both results come from it.
    send_text("(I");
    desc_bytes.delete();
    add_byte(8'h00);
    send_descriptor();
    desc_bytes.delete();
    add_byte(8'hFF);
    send_descriptor();
    wait_for_results();

    // One more parameter than the count can hold, streamed while the output
    // is held off so the result queue fills and the input backs up.
    tx_gaps = 1'b0;
    hold_output = 1'b1;
    desc_bytes.delete();
    add_byte(CH_OPEN);
    repeat (256) add_byte(scalar_char());
    add_byte(CH_CLOSE);
    add_byte(scalar_char());
    send_descriptor();
    wait_for_results();

    tx_gaps = 1'b1;
    while (bytes_sent < 550) begin
      if (bytes_sent >= 470) begin
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
      end
      build_wellformed();
      if ($urandom_range(0, 9) < 3) begin
        damage_descriptor();
      end
      send_descriptor();
    end
    wait_for_results();
    repeat (8) @(negedge clk);

    $display("Sent %0d descriptors in %0d bytes; %0d results compared.",
             descriptors_sent, bytes_sent, results_checked);
    $display("Included were empty and truncated lists, stray bytes, a held count %s",
             "and long output stalls.");
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
